// ===== hw/rtl/iprs_pkg.sv =====
// Package for the IP range section map lookup block.
// Holds action and status codes, parameter defaults and the bucket hash.
// No dependencies.
package iprs_pkg;

    localparam int RangeEntries = 64;
    localparam int HashBits     = 10;
    localparam int BucketWays   = 4;
    localparam int SectionLimit = 10;

    localparam logic [2:0] ACT_LOOKUP = 3'd0;
    localparam logic [2:0] ACT_RANGE  = 3'd1;
    localparam logic [2:0] ACT_CLASS  = 3'd2;
    localparam logic [2:0] ACT_MAP    = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_RANGE    = 3'd1;
    localparam logic [2:0] ST_SECTIONS    = 3'd2;
    localparam logic [2:0] ST_RANGE_FULL  = 3'd3;
    localparam logic [2:0] ST_BUCKET_FULL = 3'd4;
    localparam logic [2:0] ST_REVERSED    = 3'd5;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_CLASS = 2'd1;
    localparam logic [1:0] PH_MAP   = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic rng_step;   // examine one range entry
        logic map_rd;     // issue bucket read
        logic map_eval;   // evaluate bucket ways
        logic commit;     // apply writes, form result
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic rng_done;   // range search finished
        logic sweep_done; // clearing pass finished
    } t_stat;

    // Full 32-bit hash; caller keeps the low bits
    function automatic logic [31:0] hash32(input logic [31:0] ip, input logic [3:0] sec,
                                           input int hb);
        logic [31:0] sh;
        sh = ip >> hb;
        return ip ^ ((sh << 4) + sh) ^ ({28'd0, sec} * 32'd33);
    endfunction

endpackage

// ===== hw/rtl/ip_range_section_map_lookup_top.sv =====
// Top level of the IP range section map lookup block.
// Depends on iprs_pkg, iprs_ctrl and iprs_datapath.
//
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_action, i_first_ip, i_second_ip
//  output  | o_valid | i_stall | o_mapped_ip, o_found, o_status
//
// A lookup item first runs its range search, which examines no entry when no range
// is stored and otherwise examines range entries newest first, each read then compared;
// every item then passes the bucket read, way evaluation, commit and output states.
// After reset, and after a clear, a clearing pass over all 2^HASH_BITS buckets
// wipes the bucket valid memory, one bucket per cycle; no item is taken meanwhile.
// The result register holds while the output is stalled; the next item may be
// taken while it waits, and its commit holds until the register frees.
module ip_range_section_map_lookup_top #(
    parameter int RANGE_ENTRIES = iprs_pkg::RangeEntries,
    parameter int HASH_BITS     = iprs_pkg::HashBits,
    parameter int BUCKET_WAYS   = iprs_pkg::BucketWays,
    parameter int SECTION_LIMIT = iprs_pkg::SectionLimit
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_first_ip,
    input  logic [31:0] i_second_ip,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_mapped_ip,
    output logic        o_found,
    output logic [2:0]  o_status
);
    iprs_pkg::t_cmd  cmd;
    iprs_pkg::t_stat stat;
    logic            sweep;

    iprs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_action,
        .o_valid, .i_stall, .o_cmd(cmd), .o_sweep(sweep), .i_stat(stat)
    );

    iprs_datapath #(
        .RANGE_ENTRIES(RANGE_ENTRIES), .HASH_BITS(HASH_BITS),
        .BUCKET_WAYS(BUCKET_WAYS), .SECTION_LIMIT(SECTION_LIMIT)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_sweep(sweep), .o_stat(stat),
        .i_action, .i_first_ip, .i_second_ip,
        .o_mapped_ip, .o_found, .o_status
    );
endmodule

// ===== hw/rtl/iprs_datapath.sv =====
// Datapath: range tables, bucketed map memory and valid bit memory.
// Depends on iprs_pkg.
module iprs_datapath #(
    parameter int RANGE_ENTRIES = iprs_pkg::RangeEntries,
    parameter int HASH_BITS     = iprs_pkg::HashBits,
    parameter int BUCKET_WAYS   = iprs_pkg::BucketWays,
    parameter int SECTION_LIMIT = iprs_pkg::SectionLimit
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iprs_pkg::t_cmd    i_cmd,
    input  logic              i_sweep,
    output iprs_pkg::t_stat   o_stat,
    input  logic [2:0]        i_action,
    input  logic [31:0]       i_first_ip,
    input  logic [31:0]       i_second_ip,
    output logic [31:0]       o_mapped_ip,
    output logic              o_found,
    output logic [2:0]        o_status
);
    localparam int RW = $clog2(RANGE_ENTRIES + 1);
    localparam int RI = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
    localparam int BUCKETS = 1 << HASH_BITS;
    localparam int WAY_W = BUCKET_WAYS * 32;
    localparam int WI = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

    logic [31:0] r_rlo [RANGE_ENTRIES];
    logic [31:0] r_rhi [RANGE_ENTRIES];
    logic [3:0]  r_rsec[RANGE_ENTRIES];
    logic [31:0] m_src [BUCKETS][BUCKET_WAYS];
    logic [31:0] m_dst [BUCKETS][BUCKET_WAYS];
    logic [3:0]  m_sec [BUCKETS][BUCKET_WAYS];
    logic [BUCKET_WAYS-1:0] m_vld [BUCKETS];

    logic [RW-1:0] r_count, r_idx;
    logic [3:0]    r_seccnt;
    logic [1:0]    r_phase;
    logic [2:0]    r_act;
    logic [31:0]   r_a, r_b;
    logic          r_hit;
    logic [3:0]    r_hsec;
    logic [31:0]   r_q_lo, r_q_hi;
    logic [3:0]    r_q_sec;
    logic          r_pv;
    logic [HASH_BITS-1:0] r_bkt, r_sw;
    logic [WAY_W-1:0] r_rd_src, r_rd_dst;
    logic [BUCKET_WAYS*4-1:0] r_rd_sec;
    logic [BUCKET_WAYS-1:0] r_rd_vld;
    logic          r_sw_done;
    logic          r_mhit;
    logic [31:0]   r_mdst;
    logic          r_exist, r_free;
    logic [WI-1:0] r_wway;
    logic [31:0]   r_out;
    logic          r_fnd;
    logic [2:0]    r_st;

    logic [31:0] lo_v, hi_v;
    logic [3:0]  sec_new;
    logic [4:0]  sec_ext;
    logic [31:0] h;
    logic [RI-1:0] rix;
    logic        cmp_hit;

    assign lo_v = (r_act == iprs_pkg::ACT_CLASS) ? (r_a & r_b) : r_a;
    assign hi_v = (r_act == iprs_pkg::ACT_CLASS) ? (r_a | ~r_b) : r_b;
    assign sec_ext = {1'b0, r_seccnt} + ((r_phase == iprs_pkg::PH_MAP) ? 5'd1 : 5'd0);
    assign sec_new = sec_ext[3:0];
    assign rix = RI'(r_idx - RW'(1));
    assign h = iprs_pkg::hash32(r_a,
        (r_act == iprs_pkg::ACT_LOOKUP) ? r_hsec : r_seccnt, HASH_BITS);
    assign cmp_hit = r_pv && (r_b >= r_q_lo) && (r_b <= r_q_hi);

    assign o_stat.rng_done = r_hit || ((r_idx == '0) && !r_pv);
    assign o_stat.sweep_done = r_sw_done;

    // Range search: newest first; read one entry per cycle, compare it the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seccnt <= '0;
            r_phase <= iprs_pkg::PH_START;
            r_sw <= '0;
            r_sw_done <= 1'b0;
        end else begin
            if (i_sweep) begin
                m_vld[r_sw] <= '0;
                r_sw <= r_sw + HASH_BITS'(1);
                r_sw_done <= (r_sw == HASH_BITS'(BUCKETS - 1));
            end else begin
                r_sw_done <= 1'b0;
            end
            if (i_cmd.load) begin
                r_act <= i_action;
                r_a <= i_first_ip;
                r_b <= i_second_ip;
                r_idx <= r_count;
                r_hit <= 1'b0;
                r_hsec <= '0;
                r_pv <= 1'b0;
            end
            if (i_cmd.rng_step && !r_hit) begin
                if (cmp_hit) begin
                    r_hit <= 1'b1;
                    r_hsec <= r_q_sec;
                    r_pv <= 1'b0;
                end else if (r_idx != '0) begin
                    r_q_lo <= r_rlo[rix];
                    r_q_hi <= r_rhi[rix];
                    r_q_sec <= r_rsec[rix];
                    r_pv <= 1'b1;
                    r_idx <= r_idx - RW'(1);
                end else begin
                    r_pv <= 1'b0;
                end
            end
            if (i_cmd.map_rd) begin
                r_bkt <= h[HASH_BITS-1:0];
                r_rd_vld <= m_vld[h[HASH_BITS-1:0]];
                for (int w = 0; w < BUCKET_WAYS; w++) begin
                    r_rd_src[w*32 +: 32] <= m_src[h[HASH_BITS-1:0]][w];
                    r_rd_dst[w*32 +: 32] <= m_dst[h[HASH_BITS-1:0]][w];
                    r_rd_sec[w*4 +: 4]   <= m_sec[h[HASH_BITS-1:0]][w];
                end
            end
            if (i_cmd.map_eval) begin
                logic       ex, fr, mh;
                logic [31:0] md;
                logic [WI-1:0] ew, fw;
                logic [3:0] ks;
                ex = 1'b0; fr = 1'b0; mh = 1'b0; md = '0; ew = '0; fw = '0;
                ks = (r_act == iprs_pkg::ACT_LOOKUP) ? r_hsec : r_seccnt;
                for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
                    if (r_rd_vld[w]) begin
                        if (r_rd_src[w*32 +: 32] == r_a && r_rd_sec[w*4 +: 4] == ks) begin
                            ex = 1'b1; ew = WI'(w);
                            mh = 1'b1; md = r_rd_dst[w*32 +: 32];
                        end
                    end else begin
                        fr = 1'b1; fw = WI'(w);
                    end
                end
                r_exist <= ex; r_free <= fr; r_mhit <= mh; r_mdst <= md;
                r_wway <= ex ? ew : fw;
            end
            if (i_cmd.commit) begin
                r_out <= '0;
                r_fnd <= 1'b0;
                r_st <= iprs_pkg::ST_OK;
                case (r_act)
                    iprs_pkg::ACT_LOOKUP: begin
                        if (r_hit && r_mhit) begin
                            r_out <= r_mdst;
                            r_fnd <= 1'b1;
                        end
                    end
                    iprs_pkg::ACT_RANGE, iprs_pkg::ACT_CLASS: begin
                        if (hi_v < lo_v) r_st <= iprs_pkg::ST_REVERSED;
                        else if (sec_ext >= 5'(SECTION_LIMIT)) r_st <= iprs_pkg::ST_SECTIONS;
                        else if (r_count >= RW'(RANGE_ENTRIES))
                            r_st <= iprs_pkg::ST_RANGE_FULL;
                        else begin
                            r_rlo[r_count[RI-1:0]] <= lo_v;
                            r_rhi[r_count[RI-1:0]] <= hi_v;
                            r_rsec[r_count[RI-1:0]] <= sec_new;
                            r_count <= r_count + RW'(1);
                            r_seccnt <= sec_new;
                            r_phase <= iprs_pkg::PH_CLASS;
                        end
                    end
                    iprs_pkg::ACT_MAP: begin
                        if (r_phase == iprs_pkg::PH_START) r_st <= iprs_pkg::ST_NO_RANGE;
                        else if (!r_exist && !r_free) r_st <= iprs_pkg::ST_BUCKET_FULL;
                        else begin
                            m_dst[r_bkt][r_wway] <= r_b;
                            if (!r_exist) begin
                                m_src[r_bkt][r_wway] <= r_a;
                                m_sec[r_bkt][r_wway] <= r_seccnt;
                                m_vld[r_bkt][r_wway] <= 1'b1;
                            end
                            r_phase <= iprs_pkg::PH_MAP;
                        end
                    end
                    iprs_pkg::ACT_CLEAR: begin
                        r_count <= '0;
                        r_seccnt <= '0;
                        r_phase <= iprs_pkg::PH_START;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_mapped_ip = r_out;
    assign o_found = r_fnd;
    assign o_status = r_st;
endmodule

// ===== hw/rtl/iprs_ctrl.sv =====
// Controller state machine: sequences load, range search, bucket read, commit.
// Depends on iprs_pkg.
module iprs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [2:0]      i_action,
    output logic            o_valid,
    input  logic            i_stall,
    output iprs_pkg::t_cmd  o_cmd,
    output logic            o_sweep,
    input  iprs_pkg::t_stat i_stat
);
    typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_SEARCH, S_READ, S_EVAL, S_COMMIT, S_OUT}
        t_state;
    t_state r_state;
    logic   r_valid;
    logic   r_clear;

    assign o_stall = !(r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_sweep = (r_state == S_SWEEP);
    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        o_cmd.rng_step = (r_state == S_SEARCH);
        o_cmd.map_rd = (r_state == S_READ);
        o_cmd.map_eval = (r_state == S_EVAL);
        o_cmd.commit = (r_state == S_COMMIT) && (!r_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_valid <= 1'b0;
            r_clear <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            case (r_state)
                S_SWEEP: if (i_stat.sweep_done) begin
                    r_state <= r_clear ? S_OUT : S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_clear <= (i_action == iprs_pkg::ACT_CLEAR);
                    r_state <= (i_action == iprs_pkg::ACT_LOOKUP) ? S_SEARCH : S_READ;
                end
                S_SEARCH: if (i_stat.rng_done) r_state <= S_READ;
                S_READ:   r_state <= S_EVAL;
                S_EVAL:   r_state <= S_COMMIT;
                S_COMMIT: if (!r_valid || !i_stall) begin
                    r_state <= r_clear ? S_SWEEP : S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_clear <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> o_stall) else $error("second item taken");
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> o_valid) else $error("result lost");
    a_no_sweep_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sweep |-> !o_cmd.commit) else $error("commit during sweep");
endmodule
